### sv/rsde_pkg.sv
// Shared types, constants and command codes of the raster drawing engine.
package rsde_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int XW         = $clog2(MaxWidth);
    localparam int YW         = $clog2(MaxHeight);
    localparam int AW         = XW + YW;
    localparam int DimW       = 9;
    localparam int StoreDepth = MaxWidth * MaxHeight;

    typedef enum logic [2:0] {
        FUNC_SET     = 3'd0,
        FUNC_FILL    = 3'd1,
        FUNC_LINE    = 3'd2,
        FUNC_RECT    = 3'd3,
        FUNC_RFILL   = 3'd4,
        FUNC_CIRC    = 3'd5,
        FUNC_CFILL   = 3'd6,
        FUNC_READ    = 3'd7
    } func_t;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] x_first;
        logic [7:0] y_first;
        logic [7:0] x_second;
        logic [7:0] y_second;
        logic [7:0] circle_radius;
        logic [7:0] pixel_value;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       status;
    } result_t;

    // Controller to datapath.
    typedef struct packed {
        logic       load;     // capture command, restart segment scan
        logic       clear;    // write zero at clear address (reset sweep)
        logic       step;     // evaluate and advance scan
        logic       next_seg; // move to next rectangle edge
        logic       rd;       // read state; the store read itself is taken on load
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       scan_done;
        logic       last_seg;
        logic       clear_done;
    } dp_stat_t;

    // Saturate a 9-bit register write into [1, maxv].
    function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v,
                                                  input logic [DimW-1:0] maxv);
        logic [DimW-1:0] r;
        begin
            r = v;
            if (v == '0)
                r = DimW'(1);
            else if (v > maxv)
                r = maxv;
            return r;
        end
    endfunction

endpackage

### sv/rsde_ctrl.sv
// Controller state machine of the raster drawing engine.
module rsde_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        func,
    input  rsde_pkg::dp_stat_t stat,
    output rsde_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import rsde_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_SEG   = 6'b001000,
        ST_READ  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (func == FUNC_READ)
                        state_next = ST_READ;
                    else if (func == FUNC_SET)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                    state_next = stat.last_seg ? ST_DONE : ST_SEG;
            end
            ST_SEG:
            begin
                cmd.next_seg = 1'b1;
                state_next = ST_SCAN;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

### sv/rsde_datapath.sv
// Scan counters, shape test and frame store of the raster drawing engine.
module rsde_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rsde_pkg::dp_cmd_t        cmd,
    input  rsde_pkg::cmd_t           item,
    input  logic                    cfg_we,
    input  logic                    cfg_idx,
    input  logic [rsde_pkg::DimW-1:0] cfg_data,
    output rsde_pkg::dp_stat_t       stat,
    output rsde_pkg::result_t        res
);
    import rsde_pkg::*;

    logic [DimW-1:0] width_reg, height_reg;
    cmd_t            cmd_reg;
    logic [1:0]      seg_reg;
    logic [DimW-1:0] x_reg, y_reg, x_lo_reg, y_lo_reg, x_hi_reg, y_hi_reg;
    logic            draw_x_reg;   // box loaded, walk in progress (outer scan over x, inner over y)
    logic            status_reg;
    logic [AW-1:0]   clr_reg;
    logic [7:0]      rd_data_reg;
    logic            rd_ok_reg;
    logic [7:0]      store [StoreDepth];

    // Box bounds for a segment of the current command.
    logic [DimW-1:0] bx_lo, bx_hi, by_lo, by_hi;
    logic            b_ok;
    logic            l_ok;         // line is axis-aligned with both ends on the image
    logic [7:0]      lx1, ly1, lx2, ly2;
    logic [DimW-1:0] cx, cy, rr;

    always_comb
    begin
        cx = {1'b0, cmd_reg.x_first};
        cy = {1'b0, cmd_reg.y_first};
        rr = {1'b0, cmd_reg.circle_radius};
        lx1 = cmd_reg.x_first;  ly1 = cmd_reg.y_first;
        lx2 = cmd_reg.x_second; ly2 = cmd_reg.y_second;
        // A rectangle outline is drawn edge by edge, in turn.
        if (func_t'(cmd_reg.func) == FUNC_RECT)
        begin
            case (seg_reg)
                2'd0: begin lx2 = cmd_reg.x_first;  end
                2'd1: begin lx1 = cmd_reg.x_second; end
                2'd2: begin ly2 = cmd_reg.y_first;  end
                default: begin ly1 = cmd_reg.y_second; end
            endcase
        end
        bx_lo = '0; bx_hi = width_reg; by_lo = '0; by_hi = height_reg;
        b_ok = 1'b1;
        l_ok = 1'b1;
        case (func_t'(cmd_reg.func))
            FUNC_LINE, FUNC_RECT:
            begin
                l_ok = ({1'b0, lx1} < width_reg) && ({1'b0, lx2} < width_reg)
                    && ({1'b0, ly1} < height_reg) && ({1'b0, ly2} < height_reg)
                    && ((lx1 == lx2) || (ly1 == ly2));
                b_ok = l_ok;
                if (lx1 == lx2)
                begin
                    bx_lo = {1'b0, lx1};
                    bx_hi = bx_lo + DimW'(1);
                    by_lo = {1'b0, (ly1 < ly2) ? ly1 : ly2};
                    by_hi = {1'b0, (ly1 < ly2) ? ly2 : ly1};
                end
                else
                begin
                    by_lo = {1'b0, ly1};
                    by_hi = by_lo + DimW'(1);
                    bx_lo = {1'b0, (lx1 < lx2) ? lx1 : lx2};
                    bx_hi = {1'b0, (lx1 < lx2) ? lx2 : lx1};
                end
            end
            FUNC_RFILL:
            begin
                bx_lo = cx;
                by_lo = cy;
                bx_hi = ({1'b0, cmd_reg.x_second} < width_reg)
                    ? {1'b0, cmd_reg.x_second} : width_reg;
                by_hi = ({1'b0, cmd_reg.y_second} < height_reg)
                    ? {1'b0, cmd_reg.y_second} : height_reg;
            end
            FUNC_CIRC, FUNC_CFILL:
            begin
                b_ok = (rr != '0);
                bx_lo = (cx > rr) ? cx - rr : '0;
                by_lo = (cy > rr) ? cy - rr : '0;
                bx_hi = ((cx + rr) < width_reg) ? cx + rr : width_reg;
                by_hi = ((cy + rr) < height_reg) ? cy + rr : height_reg;
            end
            default: ;
        endcase
        if (!(bx_lo < bx_hi) || !(by_lo < by_hi))
            b_ok = 1'b0;
    end

    // Circle test at the scan point: squared distance against the squared radius (and inner radius for an outline).
    logic [DimW-1:0] dx, dy;
    logic [17:0]     d2, r2, in2;
    logic            hit;
    always_comb
    begin
        dx  = (x_reg > cx) ? x_reg - cx : cx - x_reg;
        dy  = (y_reg > cy) ? y_reg - cy : cy - y_reg;
        d2  = 18'({8'd0, dx[7:0]} * {8'd0, dx[7:0]})
            + 18'({8'd0, dy[7:0]} * {8'd0, dy[7:0]});
        r2  = 18'({8'd0, rr[7:0]} * {8'd0, rr[7:0]});
        in2 = 18'({8'd0, rr[7:0] - 8'd1} * {8'd0, rr[7:0] - 8'd1});
        hit = 1'b1;
        if (cmd_reg.func == FUNC_CIRC)
            hit = (d2 <= r2) && (d2 > in2);
        else if (cmd_reg.func == FUNC_CFILL)
            hit = (d2 <= r2);
    end

    // The box-loading step ends the segment only when the box is empty, the
    // line is rejected or the radius is zero; else the walk ends on the last pixel.
    logic last_y, last_x;
    assign last_y = (y_reg + DimW'(1) >= y_hi_reg);
    assign last_x = (x_reg + DimW'(1) >= x_hi_reg);
    assign stat.scan_done  = draw_x_reg ? (last_x && last_y) : !b_ok;
    assign stat.last_seg   = (cmd_reg.func != FUNC_RECT) || (seg_reg == 2'd3);
    assign stat.clear_done = (clr_reg == '1);

    logic set_ok;
    assign set_ok = ({1'b0, item.x_first} < width_reg)
        && ({1'b0, item.y_first} < height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DimW'(MaxWidth);
            height_reg <= DimW'(MaxHeight);
            clr_reg    <= '0;
            seg_reg    <= '0;
            draw_x_reg <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == CFG_WIDTH)
                    width_reg <= sat_dim(cfg_data, DimW'(MaxWidth));
                else
                    height_reg <= sat_dim(cfg_data, DimW'(MaxHeight));
            end
            if (cmd.clear && !stat.clear_done)
                clr_reg <= clr_reg + AW'(1);
            if (cmd.load)
            begin
                seg_reg    <= '0;
                draw_x_reg <= 1'b0;
                status_reg <= 1'b0;
            end
            else if (cmd.next_seg)
            begin
                seg_reg    <= seg_reg + 2'd1;
                draw_x_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (!draw_x_reg)
                begin
                    draw_x_reg <= b_ok;
                    if (cmd_reg.func == FUNC_LINE)
                        status_reg <= !l_ok;
                end
                else if (stat.scan_done)
                    draw_x_reg <= 1'b0;
            end
        end
    end

    // Scan registers: first step of a segment loads the box, later steps
    // walk it column-major, one pixel a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            cmd_reg <= item;
        if (cmd.step)
        begin
            if (!draw_x_reg)
            begin
                x_reg <= bx_lo; y_reg <= by_lo;
                x_lo_reg <= bx_lo; y_lo_reg <= by_lo;
                x_hi_reg <= bx_hi; y_hi_reg <= by_hi;
            end
            else if (last_y)
            begin
                y_reg <= y_lo_reg;
                x_reg <= x_reg + DimW'(1);
            end
            else
                y_reg <= y_reg + DimW'(1);
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            store[clr_reg] <= 8'd0;
        else if (cmd.load && item.func == FUNC_SET && set_ok)
            store[{item.x_first, item.y_first}] <= item.pixel_value;
        else if (cmd.step && draw_x_reg && hit)
            store[{x_reg[XW-1:0], y_reg[YW-1:0]}] <= cmd_reg.pixel_value;
        if (cmd.load)
        begin
            rd_data_reg <= store[{item.x_first, item.y_first}];
            rd_ok_reg   <= set_ok && (item.func == FUNC_READ);
        end
    end

    assign res.read_value = (cmd_reg.func == FUNC_READ && rd_ok_reg) ? rd_data_reg : 8'd0;
    assign res.status     = (cmd_reg.func == FUNC_LINE) && status_reg;

endmodule

### sv/raster_shape_draw_engine_top.sv
// Top level of the raster drawing engine: controller, datapath and checks.
//
// An 8-bit grayscale frame store of 256 x 256 pixels takes one drawing
// command at a time. A command transfer happens at a clock edge where
// start is high and busy is low; busy then stays high until the result
// strobe. Each command yields one result on result, marked by done for
// exactly one cycle; the receiver cannot stall it.
// Set pixel goes from idle straight to the done state; read pixel passes
// through a read state first. Shape commands walk their clipped bounding
// box one pixel per cycle. A rectangle outline walks its edges in
// turn; each edge begins with a step that sets up its box, and a segment
// step lies between edges.
// The frame store has one write port, which sets the pace of every scan.
// Configuration transfers on cfg_valid/cfg_ready set the active width
// (index 0) and height (index 1), saturated into 1..256.
// After reset a clearing pass zeroes the store, one pixel per cycle;
// busy is high then and no command is taken, while configuration
// writes are taken as ever.
module raster_shape_draw_engine_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rsde_pkg::cmd_t    cmd,
    output logic              done,
    output rsde_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [8:0]        cfg_data
);
    import rsde_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;

    rsde_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (cmd.func),
        .stat  (dp_stat),
        .cmd   (dp_cmd),
        .busy  (busy),
        .done  (done)
    );

    rsde_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .item     (cmd),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .stat     (dp_stat),
        .res      (result)
    );

    // A command is only loaded on an accepted transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load |-> (start && !busy))
        else $error("load without accepted transfer");

    // A done strobe lasts a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Store clearing and command work never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.clear |-> !(dp_cmd.step || dp_cmd.load))
        else $error("clear overlaps command");

endmodule
